@@ hdl/trilu_pkg.sv @@
`default_nettype none

package trilu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DVD_W      = DATA_WIDTH + FRAC_BITS;
    localparam int CNT_W      = $clog2(DVD_W);

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        t_data diag_elem;
        t_data super_elem;
        t_data sub_elem;
        logic  last_row;
    } t_in_item;

    typedef struct packed {
        t_data u_diag;
        t_data u_super1;
        t_data u_super2;
        t_data l_mult;
        logic  pivoted;
        logic  det_negative;
        logic  div_overflow;
        logic  last_result;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_FETCH,
        OP_SELECT,
        OP_ZCHK,
        OP_DIV,
        OP_QFIX,
        OP_MUL1,
        OP_UPD1,
        OP_MUL2,
        OP_UPD2,
        OP_EMIT,
        OP_EMIT_LAST,
        OP_STORE,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic slot_free;
        logic have_row;
        logic last;
        logic ud_zero;
        logic div_more;
    } t_status;

endpackage

`default_nettype wire

@@ hdl/trilu_in_if.sv @@
`default_nettype none

interface trilu_in_if;
    logic                valid;
    logic                ready;
    trilu_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/trilu_out_if.sv @@
`default_nettype none

interface trilu_out_if;
    logic                 valid;
    logic                 ready;
    trilu_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/trilu_sequencer.sv @@
`default_nettype none

module trilu_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  trilu_pkg::t_status i_status,
    output trilu_pkg::t_ctrl   o_ctrl
);

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOROW,
        C_NOTLAST,
        C_UDZERO,
        C_DIVMORE
    } t_cond;

    typedef logic [3:0] t_pc;

    typedef struct packed {
        trilu_pkg::t_op op;
        t_cond          cond;
        t_pc            target;
    } t_uword;

    localparam t_pc S_FETCH     = 4'd0;
    localparam t_pc S_SELECT    = 4'd1;
    localparam t_pc S_ZCHK      = 4'd2;
    localparam t_pc S_DIV       = 4'd3;
    localparam t_pc S_QFIX      = 4'd4;
    localparam t_pc S_MUL1      = 4'd5;
    localparam t_pc S_UPD1      = 4'd6;
    localparam t_pc S_MUL2      = 4'd7;
    localparam t_pc S_UPD2      = 4'd8;
    localparam t_pc S_EMIT      = 4'd9;
    localparam t_pc S_EMIT_LAST = 4'd10;
    localparam t_pc S_STORE     = 4'd11;
    localparam t_pc S_STORE_FIN = 4'd12;

    function automatic t_uword f_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            S_FETCH:     w = '{trilu_pkg::OP_FETCH,     C_NOROW,   S_STORE};
            S_SELECT:    w = '{trilu_pkg::OP_SELECT,    C_NEVER,   S_FETCH};
            S_ZCHK:      w = '{trilu_pkg::OP_ZCHK,      C_UDZERO,  S_MUL1};
            S_DIV:       w = '{trilu_pkg::OP_DIV,       C_DIVMORE, S_DIV};
            S_QFIX:      w = '{trilu_pkg::OP_QFIX,      C_NEVER,   S_FETCH};
            S_MUL1:      w = '{trilu_pkg::OP_MUL1,      C_NEVER,   S_FETCH};
            S_UPD1:      w = '{trilu_pkg::OP_UPD1,      C_NEVER,   S_FETCH};
            S_MUL2:      w = '{trilu_pkg::OP_MUL2,      C_NEVER,   S_FETCH};
            S_UPD2:      w = '{trilu_pkg::OP_UPD2,      C_NEVER,   S_FETCH};
            S_EMIT:      w = '{trilu_pkg::OP_EMIT,      C_NOTLAST, S_FETCH};
            S_EMIT_LAST: w = '{trilu_pkg::OP_EMIT_LAST, C_ALWAYS,  S_FETCH};
            S_STORE:     w = '{trilu_pkg::OP_STORE,     C_NOTLAST, S_FETCH};
            S_STORE_FIN: w = '{trilu_pkg::OP_EMIT_LAST, C_ALWAYS,  S_FETCH};
            default:     w = '{trilu_pkg::OP_NOP,       C_ALWAYS,  S_FETCH};
        endcase
        return w;
    endfunction

    t_pc    r_pc;
    t_uword w_word;
    logic   w_jump;
    logic   w_stall;

    assign w_word = f_rom(r_pc);

    always_comb begin
        unique case (w_word.cond)
            C_NEVER:   w_jump = 1'b0;
            C_ALWAYS:  w_jump = 1'b1;
            C_NOROW:   w_jump = !i_status.have_row;
            C_NOTLAST: w_jump = !i_status.last;
            C_UDZERO:  w_jump = i_status.ud_zero;
            C_DIVMORE: w_jump = i_status.div_more;
            default:   w_jump = 1'b0;
        endcase
    end

    assign w_stall = ((w_word.op == trilu_pkg::OP_FETCH) && !i_status.in_valid)
                  || (((w_word.op == trilu_pkg::OP_EMIT)
                       || (w_word.op == trilu_pkg::OP_EMIT_LAST))
                      && !i_status.slot_free);

    assign o_ctrl.op   = w_word.op;
    assign o_ctrl.fire = !w_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_FETCH;
        end else if (!w_stall) begin
            if (w_jump) begin
                r_pc <= w_word.target;
            end else begin
                r_pc <= r_pc + 4'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/tridiagonal_lu_partial_pivot_core.sv @@
// Channel  Dir  Modport  Item
// i_row    in   sink     one matrix row: diag_elem, super_elem, sub_elem, last_row
// o_res    out  source   one finished U row with multiplier, pivot and sign flags
//
// A row after the first is fetched, selected, zero-checked, divided in 48 restoring
// divide steps of one quotient bit, fixed up, run through two multiply/update pairs
// and emitted. A zero pivot skips divide and fix-up. The first row is only fetched
// and stored; the final row also emits an extra result. Synchronous reset returns to
// fetch and drops any pending row; a stalled result holds the emit step, and ready
// is high only at fetch.
`default_nettype none

module tridiagonal_lu_partial_pivot_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trilu_in_if.sink    i_row,
    trilu_out_if.source o_res
);

    localparam int DW   = trilu_pkg::DATA_WIDTH;
    localparam int FB   = trilu_pkg::FRAC_BITS;
    localparam int DVDW = trilu_pkg::DVD_W;
    localparam int CW   = trilu_pkg::CNT_W;

    localparam logic [DVDW-1:0] LIM_POS = {{(DVDW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [DVDW-1:0] LIM_NEG = {{(DVDW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW+1:0] W_MAX = {3'b000, {(DW-1){1'b1}}};
    localparam logic signed [DW+1:0] W_MIN = {3'b111, {(DW-1){1'b0}}};
    localparam logic [CW-1:0] CNT_LAST = CW'(DVDW - 1);

    function automatic logic [DW-1:0] f_mag(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    trilu_pkg::t_ctrl   w_ctrl;
    trilu_pkg::t_status w_status;

    trilu_pkg::t_data     r_d, r_e, r_c;
    logic                 r_last;
    trilu_pkg::t_data     r_pend_diag, r_pend_super, r_pend_sub;
    logic                 r_have_row;
    logic                 r_parity;
    trilu_pkg::t_data     r_ud, r_u1, r_u2, r_rd, r_rs;
    logic                 r_piv;
    logic [DW-1:0]        r_dm;
    logic [DVDW-1:0]      r_dvd;
    logic [DW-1:0]        r_rem;
    logic [CW-1:0]        r_cnt;
    logic                 r_qneg;
    trilu_pkg::t_data     r_l;
    logic                 r_ov;
    logic [2*DW-1:0]      r_prod;
    logic                 r_pneg;
    trilu_pkg::t_data     r_nd, r_ns;
    trilu_pkg::t_out_item r_out;
    logic                 r_out_valid;

    logic                 w_piv;
    trilu_pkg::t_data     w_ud, w_u1, w_u2, w_low, w_rd, w_rs;
    logic [DW:0]          w_rem_sh;
    logic                 w_qb;
    logic [DW:0]          w_rem_diff;
    logic [DVDW-1:0]      w_lim;
    logic                 w_qov;
    logic [DW-1:0]        w_qmag;
    trilu_pkg::t_data     w_mul_b;
    logic [2*DW-1:0]      w_prod;
    logic [DW-1:0]        w_m;
    trilu_pkg::t_data     w_a;
    logic signed [DW+1:0] w_aw, w_mw, w_diff;
    trilu_pkg::t_data     w_upd;
    logic                 w_slot_free;

    trilu_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    assign w_slot_free = !r_out_valid || o_res.ready;

    assign w_status.in_valid  = i_row.valid;
    assign w_status.slot_free = w_slot_free;
    assign w_status.have_row  = r_have_row;
    assign w_status.last      = r_last;
    assign w_status.ud_zero   = (r_ud == '0);
    assign w_status.div_more  = (r_cnt != '0);

    assign i_row.ready = (w_ctrl.op == trilu_pkg::OP_FETCH);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // pivot selection
    assign w_piv = f_mag(r_pend_sub) > f_mag(r_pend_diag);
    assign w_ud  = w_piv ? r_pend_sub   : r_pend_diag;
    assign w_u1  = w_piv ? r_d          : r_pend_super;
    assign w_u2  = w_piv ? r_e          : '0;
    assign w_low = w_piv ? r_pend_diag  : r_pend_sub;
    assign w_rd  = w_piv ? r_pend_super : r_d;
    assign w_rs  = w_piv ? '0           : r_e;

    // one restoring divide step
    assign w_rem_sh   = {r_rem, r_dvd[DVDW-1]};
    assign w_qb       = (w_rem_sh >= {1'b0, r_dm});
    assign w_rem_diff = w_rem_sh - {1'b0, r_dm};

    // quotient saturation
    assign w_lim  = r_qneg ? LIM_NEG : LIM_POS;
    assign w_qov  = (r_dvd > w_lim);
    assign w_qmag = w_qov ? w_lim[DW-1:0] : r_dvd[DW-1:0];

    // shared multiplier
    assign w_mul_b = (w_ctrl.op == trilu_pkg::OP_MUL2) ? r_u2 : r_u1;
    assign w_prod  = f_mag(r_l) * f_mag(w_mul_b);

    // row update with saturation
    assign w_m    = (|r_prod[2*DW-1:DW+FB]) ? '1 : r_prod[DW+FB-1:FB];
    assign w_a    = (w_ctrl.op == trilu_pkg::OP_UPD2) ? r_rs : r_rd;
    assign w_aw   = {{2{w_a[DW-1]}}, w_a};
    assign w_mw   = {2'b00, w_m};
    assign w_diff = r_pneg ? (w_aw + w_mw) : (w_aw - w_mw);
    assign w_upd  = (w_diff > W_MAX) ? W_MAX[DW-1:0]
                  : (w_diff < W_MIN) ? W_MIN[DW-1:0]
                  : w_diff[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_row  <= 1'b0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctrl.fire && ((w_ctrl.op == trilu_pkg::OP_EMIT)
                                || (w_ctrl.op == trilu_pkg::OP_EMIT_LAST))) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_ctrl.fire) begin
                unique case (w_ctrl.op)
                    trilu_pkg::OP_SELECT: begin
                        r_parity <= r_parity ^ w_piv;
                    end
                    trilu_pkg::OP_EMIT_LAST: begin
                        r_have_row  <= 1'b0;
                        r_parity    <= 1'b0;
                    end
                    trilu_pkg::OP_STORE: begin
                        r_have_row <= 1'b1;
                        r_parity   <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.fire) begin
            unique case (w_ctrl.op)
                trilu_pkg::OP_FETCH: begin
                    r_d    <= i_row.data.diag_elem;
                    r_e    <= i_row.data.last_row ? '0 : i_row.data.super_elem;
                    r_c    <= i_row.data.last_row ? '0 : i_row.data.sub_elem;
                    r_last <= i_row.data.last_row;
                end
                trilu_pkg::OP_SELECT: begin
                    r_ud   <= w_ud;
                    r_u1   <= w_u1;
                    r_u2   <= w_u2;
                    r_rd   <= w_rd;
                    r_rs   <= w_rs;
                    r_piv  <= w_piv;
                    r_dm   <= f_mag(w_ud);
                    r_dvd  <= {f_mag(w_low), {FB{1'b0}}};
                    r_rem  <= '0;
                    r_cnt  <= CNT_LAST;
                    r_qneg <= w_low[DW-1] ^ w_ud[DW-1];
                end
                trilu_pkg::OP_ZCHK: begin
                    r_l  <= '0;
                    r_ov <= 1'b0;
                end
                trilu_pkg::OP_DIV: begin
                    r_rem <= w_qb ? w_rem_diff[DW-1:0] : w_rem_sh[DW-1:0];
                    r_dvd <= {r_dvd[DVDW-2:0], w_qb};
                    r_cnt <= r_cnt - 1'b1;
                end
                trilu_pkg::OP_QFIX: begin
                    r_l  <= r_qneg ? (~w_qmag + 1'b1) : w_qmag;
                    r_ov <= w_qov;
                end
                trilu_pkg::OP_MUL1, trilu_pkg::OP_MUL2: begin
                    r_prod <= w_prod;
                    r_pneg <= r_l[DW-1] ^ w_mul_b[DW-1];
                end
                trilu_pkg::OP_UPD1: begin
                    r_nd <= w_upd;
                end
                trilu_pkg::OP_UPD2: begin
                    r_ns <= w_upd;
                end
                trilu_pkg::OP_EMIT: begin
                    r_out.u_diag       <= r_ud;
                    r_out.u_super1     <= r_u1;
                    r_out.u_super2     <= r_u2;
                    r_out.l_mult       <= r_l;
                    r_out.pivoted      <= r_piv;
                    r_out.det_negative <= r_parity;
                    r_out.div_overflow <= r_ov;
                    r_out.last_result  <= 1'b0;
                    r_pend_diag        <= r_nd;
                    r_pend_super       <= r_ns;
                    r_pend_sub         <= r_c;
                end
                trilu_pkg::OP_EMIT_LAST: begin
                    r_out.u_diag       <= r_pend_diag;
                    r_out.u_super1     <= r_pend_super;
                    r_out.u_super2     <= '0;
                    r_out.l_mult       <= '0;
                    r_out.pivoted      <= 1'b0;
                    r_out.det_negative <= r_parity;
                    r_out.div_overflow <= 1'b0;
                    r_out.last_result  <= 1'b1;
                end
                trilu_pkg::OP_STORE: begin
                    r_pend_diag  <= r_d;
                    r_pend_super <= r_e;
                    r_pend_sub   <= r_c;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/trilu_checker.sv @@
`default_nettype none

module trilu_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input trilu_pkg::t_out_item i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result item changed or dropped while stalled");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("row accepted on two consecutive cycles");

    a_final_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.last_result |->
            !i_out_data.pivoted && !i_out_data.div_overflow
            && (i_out_data.l_mult == '0) && (i_out_data.u_super2 == '0))
        else $error("final diagonal item carries row fields");

    a_emit_not_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result produced from the fetch step");

endmodule

bind tridiagonal_lu_partial_pivot_core trilu_checker u_trilu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_row.valid),
    .i_in_ready  (i_row.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

`default_nettype wire

@@ tb/sv/tridiagonal_lu_partial_pivot_core_tb.sv @@
`timescale 1ns / 100ps

module tridiagonal_lu_partial_pivot_core_tb;

    import trilu_pkg::*;

    logic i_clk;
    logic i_rst_n;

    trilu_in_if  row_if();
    trilu_out_if res_if();

    tridiagonal_lu_partial_pivot_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_if),
        .o_res   (res_if)
    );

    t_out_item u_rows_due[$];

    t_data held_diag;
    t_data held_super;
    t_data held_sub;
    logic  held_valid;
    logic  swap_odd;

    logic idle_in;
    logic idle_out;

    int errors;
    int rows_sent;
    int results_seen;
    int matrices;
    int pivots_seen;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tridiagonal_lu_partial_pivot_core verification failed");
        $finish;
    end

    function automatic logic [DATA_WIDTH:0] abs_val(input t_data v);
        logic signed [DATA_WIDTH:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    // a - x*y, product truncated toward zero, difference saturated
    function automatic t_data mac_sat(input t_data a, input t_data x, input t_data y);
        logic [2*DATA_WIDTH+1:0]      prod;
        logic [DATA_WIDTH-1:0]        m;
        logic signed [DATA_WIDTH+2:0] acc;
        prod = abs_val(x) * abs_val(y);
        prod = prod >> FRAC_BITS;
        m = (prod > {DATA_WIDTH{1'b1}}) ? {DATA_WIDTH{1'b1}} : prod[DATA_WIDTH-1:0];
        acc = a;
        if (x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1])
            acc = acc + $signed({3'b000, m});
        else
            acc = acc - $signed({3'b000, m});
        if (acc[DATA_WIDTH+2:DATA_WIDTH-1] != {4{acc[DATA_WIDTH+2]}})
            return acc[DATA_WIDTH+2] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                     : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        return acc[DATA_WIDTH-1:0];
    endfunction

    task automatic div_mult(input t_data num, input t_data den, output t_data quo,
                            output logic ovf);
        logic [2*DATA_WIDTH-1:0] nmr;
        logic [2*DATA_WIDTH-1:0] q;
        logic [2*DATA_WIDTH-1:0] lim;
        logic                    neg;
        neg = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
        nmr = abs_val(num);
        nmr = nmr << FRAC_BITS;
        q = nmr / abs_val(den);
        lim = '0;
        lim[DATA_WIDTH-1] = 1'b1;
        if (!neg)
            lim = lim - 1;
        ovf = (q > lim);
        if (ovf)
            q = lim;
        if (neg)
            q = -q;
        quo = q[DATA_WIDTH-1:0];
    endtask

    task automatic clear_held();
        held_diag  = '0;
        held_super = '0;
        held_sub   = '0;
        held_valid = 1'b0;
        swap_odd   = 1'b0;
    endtask

    task automatic factor_row(input t_in_item row);
        t_data     d, e, c, ud, u1, u2, low, rd, rs, l;
        logic      piv, ovf;
        t_out_item res;
        d = row.diag_elem;
        e = row.last_row ? '0 : row.super_elem;
        c = row.last_row ? '0 : row.sub_elem;
        if (!held_valid) begin
            held_diag  = d;
            held_super = e;
            held_sub   = c;
            held_valid = 1'b1;
            swap_odd   = 1'b0;
        end else begin
            piv = abs_val(held_sub) > abs_val(held_diag);
            if (piv) begin
                ud = held_sub;  u1 = d;          u2 = e;
                low = held_diag; rd = held_super; rs = '0;
            end else begin
                ud = held_diag; u1 = held_super; u2 = '0;
                low = held_sub;  rd = d;          rs = e;
            end
            swap_odd = swap_odd ^ piv;
            l = '0;
            ovf = 1'b0;
            if (ud != '0)
                div_mult(low, ud, l, ovf);
            held_diag  = mac_sat(rd, l, u1);
            held_super = mac_sat(rs, l, u2);
            held_sub   = c;
            res.u_diag       = ud;
            res.u_super1     = u1;
            res.u_super2     = u2;
            res.l_mult       = l;
            res.pivoted      = piv;
            res.det_negative = swap_odd;
            res.div_overflow = ovf;
            res.last_result  = 1'b0;
            u_rows_due.push_back(res);
            if (piv)
                pivots_seen++;
        end
        if (row.last_row) begin
            res.u_diag       = held_diag;
            res.u_super1     = held_super;
            res.u_super2     = '0;
            res.l_mult       = '0;
            res.pivoted      = 1'b0;
            res.det_negative = swap_odd;
            res.div_overflow = 1'b0;
            res.last_result  = 1'b1;
            u_rows_due.push_back(res);
            clear_held();
        end
    endtask

    task automatic cmp_field(input string name, input logic [DATA_WIDTH-1:0] want, got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (u_rows_due.size() == 0) begin
            $error("result with nothing expected: u_diag %h, last_result %b",
                   got.u_diag, got.last_result);
            errors++;
        end else begin
            want = u_rows_due.pop_front();
            cmp_field("u_diag", want.u_diag, got.u_diag);
            cmp_field("u_super1", want.u_super1, got.u_super1);
            cmp_field("u_super2", want.u_super2, got.u_super2);
            cmp_field("l_mult", want.l_mult, got.l_mult);
            cmp_field("pivoted", want.pivoted, got.pivoted);
            cmp_field("det_negative", want.det_negative, got.det_negative);
            cmp_field("div_overflow", want.div_overflow, got.div_overflow);
            cmp_field("last_result", want.last_result, got.last_result);
        end
    endtask

    initial begin : result_monitor
        int stall;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                check_result(res_if.data);
                stall = idle_out ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_row(input t_in_item it);
        int gap;
        gap = idle_in ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            row_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row_if.valid <= 1'b1;
        row_if.data  <= it;
        do @(posedge i_clk); while (row_if.ready !== 1'b1);
        factor_row(it);
        rows_sent++;
    endtask

    task automatic hold_until_drained();
        row_if.valid <= 1'b0;
        @(posedge i_clk);
        while (u_rows_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_item mk_row(input t_data d, input t_data e, input t_data c,
                                        input logic last);
        t_in_item it;
        it.diag_elem  = d;
        it.super_elem = e;
        it.sub_elem   = c;
        it.last_row   = last;
        return it;
    endfunction

    function automatic t_data rand_elem();
        t_data v;
        v = $urandom_range(0, 32'h0004_0000);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            3:       return $urandom_range(0, 1) ? t_data'(1) : t_data'(-1);
            4, 5, 6: return $urandom_range(0, 1) ? -v : v;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_matrix(input int rows);
        t_in_item it;
        for (int k = 0; k < rows; k++) begin
            it.diag_elem  = rand_elem();
            it.super_elem = rand_elem();
            it.sub_elem   = rand_elem();
            it.last_row   = (k == rows - 1);
            // usually tidy final row, sometimes junk in the off-diagonals
            if (it.last_row && $urandom_range(0, 3) != 0) begin
                it.super_elem = '0;
                it.sub_elem   = '0;
            end
            send_row(it);
        end
        matrices++;
    endtask

    task automatic test_directed();
        idle_in  = 1'b1;
        idle_out = 1'b1;
        // one-row matrices, the first with junk super and sub on the final row
        send_row(mk_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1));
        send_row(mk_row(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));
        // no pivot
        send_row(mk_row(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 1'b0));
        send_row(mk_row(32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));
        // pivot with fill-in
        send_row(mk_row(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b0));
        send_row(mk_row(32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 1'b0));
        send_row(mk_row(32'h0007_0000, 32'h1234_5678, 32'h0FED_CBA9, 1'b1));
        // zero pivot
        send_row(mk_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0));
        send_row(mk_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0));
        send_row(mk_row(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));
        // equal magnitudes, no swap
        send_row(mk_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        send_row(mk_row(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));
        send_row(mk_row(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));
        // update saturates low, then high
        send_row(mk_row(32'h0001_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0));
        send_row(mk_row(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));
        send_row(mk_row(32'h0001_0000, 32'h8000_0000, 32'h0001_0000, 1'b0));
        send_row(mk_row(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1));
        // tiny and extreme operands
        send_row(mk_row(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b0));
        send_row(mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_row(mk_row(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        send_row(mk_row(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1));
        matrices += 9;
    endtask

    task automatic test_random_matrices(input int row_target);
        int goal;
        goal = rows_sent + row_target;
        while (rows_sent < goal) begin
            // leave some stretches without idling
            idle_in  = ($urandom_range(0, 3) != 0);
            idle_out = ($urandom_range(0, 3) != 0);
            send_matrix(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                    : $urandom_range(1, 8));
        end
    endtask

    task automatic test_pause_mid_matrix(input int rounds);
        t_in_item it;
        idle_in  = 1'b1;
        idle_out = 1'b1;
        repeat (rounds) begin
            for (int k = 0; k < 6; k++) begin
                it.diag_elem  = rand_elem();
                it.super_elem = (k == 5) ? '0 : rand_elem();
                it.sub_elem   = (k == 5) ? '0 : rand_elem();
                it.last_row   = (k == 5);
                // hold until every result is out, with a row still pending
                if (k == 3)
                    hold_until_drained();
                send_row(it);
            end
            matrices++;
            hold_until_drained();
        end
    endtask

    task automatic test_back_to_back(input int row_target);
        int goal;
        idle_in  = 1'b0;
        idle_out = 1'b0;
        goal = rows_sent + row_target;
        while (rows_sent < goal)
            send_matrix($urandom_range(1, 8));
    endtask

    initial begin
        errors       = 0;
        rows_sent    = 0;
        results_seen = 0;
        matrices     = 0;
        pivots_seen  = 0;
        idle_in      = 1'b0;
        idle_out     = 1'b0;
        clear_held();
        i_rst_n      <= 1'b0;
        row_if.valid <= 1'b0;
        row_if.data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_pause_mid_matrix(8);
        test_random_matrices(620);
        test_back_to_back(100);

        hold_until_drained();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d rows in %0d matrices, %0d results checked, %0d with a swap.",
                 rows_sent, matrices, results_seen, pivots_seen);
        $display("Included zero pivots, saturating updates, drained pauses and idle-free runs.");
        if (errors == 0) begin
            $display("tridiagonal_lu_partial_pivot_core verification clean");
        end else begin
            $display("tridiagonal_lu_partial_pivot_core verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/trilu_pkg.sv
hdl/trilu_in_if.sv
hdl/trilu_out_if.sv
hdl/trilu_sequencer.sv
hdl/tridiagonal_lu_partial_pivot_core.sv
hdl/trilu_checker.sv
tb/sv/tridiagonal_lu_partial_pivot_core_tb.sv
